@@ hw/rtl/b64d_pkg.sv @@
`timescale 1ns / 1ps

package b64d_pkg;

  // Default depth of the result queue (power of two, at least 4)
  localparam int Q_DEPTH_DEF = 8;

  // Most results one character can cause
  localparam int MAX_RES = 3;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Sextet lookup: bit 6 set marks a byte outside the alphabet
  localparam logic [6:0] SEXTET_BAD = 7'h40;

  // One result word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_string;
    logic       bad_input;
  } res_t;

  // Map a character to its 6-bit value, or SEXTET_BAD
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    v = SEXTET_BAD;
    if (c inside {[8'h41:8'h5A]}) begin
      v = {1'b0, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      v = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c inside {[8'h30:8'h39]}) begin
      v = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      v = 7'd62;
    end else if (c == 8'h2F) begin
      v = 7'd63;
    end
    return v;
  endfunction

  // Space, tab, newline, carriage return
  function automatic logic is_blank(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0A, 8'h0D};
  endfunction

endpackage

@@ hw/rtl/b64d_if.sv @@
`timescale 1ns / 1ps

// Character channel
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       char_valid;
  logic       string_end;

  modport source (output valid, output char_in, output char_valid, output string_end,
                  input ready);
  modport sink (input valid, input char_in, input char_valid, input string_end,
                output ready);
endinterface

// Decoded byte channel
interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_string;
  logic       bad_input;

  modport source (output valid, output data_byte, output byte_valid,
                  output end_of_string, output bad_input, input ready);
  modport sink (input valid, input data_byte, input byte_valid,
                input end_of_string, input bad_input, output ready);
endinterface

@@ hw/rtl/base64_stream_decoder.sv @@
`timescale 1ns / 1ps

// Streaming base64 decoder (standard alphabet, '=' padding, blanks dropped).
// Takes one character word per cycle while the result queue has room and gives
// one decoded byte word per cycle while the consumer is ready; a character is
// registered, decoded once the queue has room, and its up to three results
// are written into a small result queue, so the first byte of a group passes
// the input register and the queue. The input stalls only while the queue has
// fewer than three free entries (QUEUE_DEPTH, default 8). On the final word of
// a string the last result carries end_of_string and bad_input; if bad_input
// is 1, all bytes of that string must be discarded by the consumer.
module base64_stream_decoder
  import b64d_pkg::*;
#(
  parameter int QUEUE_DEPTH = Q_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  b64d_in_if.sink      in_if,
  b64d_out_if.source   out_if
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam logic [CNT_W-1:0] ROOM_LIM = CNT_W'(QUEUE_DEPTH - MAX_RES);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(QUEUE_DEPTH);

  // Input register
  logic       ivld_r;
  logic [7:0] char_r;
  logic       cv_r;
  logic       se_r;

  // Decoder state
  logic [1:0]  pos_r, pos_nxt;
  logic [17:0] acc_r, acc_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic        closed_r, closed_nxt;
  logic        err_r, err_nxt;

  // Result queue
  res_t             q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic       proc;
  logic       pop;
  logic [1:0] n_res;
  res_t       res [MAX_RES];

  assign proc = ivld_r && (cnt_r <= ROOM_LIM);
  assign pop  = out_if.valid && out_if.ready;

  assign in_if.ready = !ivld_r || proc;

  // Capture the next character word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r <= 1'b0;
    end else if (in_if.ready) begin
      ivld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      char_r <= in_if.char_in;
      cv_r   <= in_if.char_valid;
      se_r   <= in_if.string_end;
    end
  end

  // Decode one character: next state and its results
  always_comb begin
    logic [6:0]  sx;
    logic        sig;
    logic        fin;
    logic [5:0]  last6;
    logic [1:0]  nb;
    logic [23:0] triple;
    logic [1:0]  idx;
    sx     = sextet_of(char_r);
    sig    = cv_r && !is_blank(char_r) && !err_r;
    fin    = 1'b0;
    last6  = '0;
    nb     = '0;
    idx    = '0;
    pos_nxt    = pos_r;
    acc_nxt    = acc_r;
    pad_nxt    = pad_r;
    closed_nxt = closed_r;
    err_nxt    = err_r;

    if (sig) begin
      if (closed_r) begin
        err_nxt = 1'b1;
      end else if (char_r == PAD_CHAR) begin
        if (pos_r < 2'd2) begin
          err_nxt = 1'b1;
        end else if (pos_r == 2'd2) begin
          acc_nxt = {acc_r[11:0], 6'd0};
          pad_nxt = 2'd1;
          pos_nxt = 2'd3;
        end else begin
          fin = 1'b1;
          nb  = (pad_r == 2'd0) ? 2'd2 : 2'd1;
        end
      end else begin
        if (sx[6] || pad_r != 2'd0) begin
          err_nxt = 1'b1;
        end else if (pos_r < 2'd3) begin
          acc_nxt = {acc_r[11:0], sx[5:0]};
          pos_nxt = pos_r + 2'd1;
        end else begin
          fin   = 1'b1;
          last6 = sx[5:0];
          nb    = 2'd3;
        end
      end
    end

    // Close the group
    if (fin) begin
      closed_nxt = (nb != 2'd3);
      pos_nxt    = '0;
      acc_nxt    = '0;
      pad_nxt    = '0;
    end

    triple = {acc_r, last6};
    res[0] = '{data_byte: triple[23:16], byte_valid: 1'b1, end_of_string: 1'b0,
               bad_input: 1'b0};
    res[1] = '{data_byte: triple[15:8], byte_valid: 1'b1, end_of_string: 1'b0,
               bad_input: 1'b0};
    res[2] = '{data_byte: triple[7:0], byte_valid: 1'b1, end_of_string: 1'b0,
               bad_input: 1'b0};
    n_res  = fin ? nb : 2'd0;

    // Mark the end of the string and return to reset state
    if (se_r) begin
      if (pos_nxt != 2'd0) begin
        err_nxt = 1'b1;
      end
      if (n_res == 2'd0) begin
        res[0] = '0;
        n_res  = 2'd1;
      end
      idx = n_res - 2'd1;
      res[idx].end_of_string = 1'b1;
      res[idx].bad_input     = err_nxt;
      pos_nxt    = '0;
      acc_nxt    = '0;
      pad_nxt    = '0;
      closed_nxt = 1'b0;
      err_nxt    = 1'b0;
    end
  end

  assign cnt_nxt = cnt_r + (proc ? CNT_W'(n_res) : CNT_W'(0)) - CNT_W'(pop);

  // Hold state, advance queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      acc_r    <= '0;
      pad_r    <= '0;
      closed_r <= 1'b0;
      err_r    <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (proc) begin
        pos_r    <= pos_nxt;
        acc_r    <= acc_nxt;
        pad_r    <= pad_nxt;
        closed_r <= closed_nxt;
        err_r    <= err_nxt;
        wr_ptr_r <= wr_ptr_r + PTR_W'(n_res);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Write results into the queue
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (proc && 2'(k) < n_res) begin
        q_r[wr_ptr_r + PTR_W'(k)] <= res[k];
      end
    end
  end

  assign out_if.valid         = (cnt_r != '0);
  assign out_if.data_byte     = q_r[rd_ptr_r].data_byte;
  assign out_if.byte_valid    = q_r[rd_ptr_r].byte_valid;
  assign out_if.end_of_string = q_r[rd_ptr_r].end_of_string;
  assign out_if.bad_input     = q_r[rd_ptr_r].bad_input;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("result queue overflow");

  a_marker_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.byte_valid |-> out_if.end_of_string)
    else $error("byte-less result without end_of_string");

  a_bad_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.bad_input |-> out_if.end_of_string)
    else $error("bad_input outside end result");

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    proc && se_r |=> pos_r == 2'd0 && pad_r == 2'd0 && !closed_r && !err_r)
    else $error("state not cleared after end of string");

endmodule
